### hw/rtl/mshm_pkg.sv
// Shared types, constants and the per-kind micro-op program for the
// mesh element measure block. No dependencies.
package mshm_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int ADDR_W       = 3;
  localparam int CNT_W        = 4;
  localparam int PC_W         = 5;

  // element kinds
  localparam logic [2:0] KIND_TRI   = 3'd0;
  localparam logic [2:0] KIND_QUAD  = 3'd1;
  localparam logic [2:0] KIND_TET   = 3'd2;
  localparam logic [2:0] KIND_PYR   = 3'd3;
  localparam logic [2:0] KIND_PRISM = 3'd4;
  localparam logic [2:0] KIND_HEX   = 3'd5;

  // micro-op codes
  localparam logic [2:0] OP_VSET   = 3'd0;  // dst  = v[i] - v[j]
  localparam logic [2:0] OP_VADD   = 3'd1;  // dst += v[i] - v[j]
  localparam logic [2:0] OP_CROSS  = 3'd2;  // n = B x C
  localparam logic [2:0] OP_TRIPLE = 3'd3;  // n = B x C, acc += A . n
  localparam logic [2:0] OP_AREA   = 3'd4;  // measure = isqrt(16384 |n|^2)
  localparam logic [2:0] OP_VOL128 = 3'd5;  // volume numerator = acc * 128
  localparam logic [2:0] OP_VOL64  = 3'd6;  // volume numerator = acc * 64
  localparam logic [2:0] OP_END    = 3'd7;

  // vector register select
  localparam logic [1:0] VR_A = 2'd0;
  localparam logic [1:0] VR_B = 2'd1;
  localparam logic [1:0] VR_C = 2'd2;

  localparam logic [3:0] VOL_DEN = 4'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] dst;
    logic [2:0] vi;
    logic [2:0] vj;
  } uop_t;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [36:0] x;
    logic signed [36:0] y;
    logic signed [36:0] z;
  } nvec_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic [3:0]         den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic uop_t mk(logic [2:0] op, logic [1:0] dst, logic [2:0] vi,
                              logic [2:0] vj);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.vi  = vi;
    u.vj  = vj;
    return u;
  endfunction

  function automatic logic [3:0] need_count(logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_TRI:   n = 4'd3;
      KIND_QUAD:  n = 4'd4;
      KIND_TET:   n = 4'd4;
      KIND_PYR:   n = 4'd5;
      KIND_PRISM: n = 4'd6;
      KIND_HEX:   n = 4'd8;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  // Program of vector ops for each kind. Solids of six and eight vertices
  // sum three triple products over edge vectors.
  function automatic uop_t prog_uop(logic [2:0] kind, logic [PC_W-1:0] pc);
    logic [2:0] i6, i3, i2, i0, i7, i4, i1, i5;
    uop_t u;
    u = mk(OP_END, VR_A, 3'd0, 3'd0);
    if (kind == KIND_PRISM) begin
      i6 = 3'd5; i3 = 3'd2; i2 = 3'd2; i0 = 3'd0;
      i7 = 3'd5; i4 = 3'd3; i1 = 3'd1; i5 = 3'd4;
    end else begin
      i6 = 3'd6; i3 = 3'd3; i2 = 3'd2; i0 = 3'd0;
      i7 = 3'd7; i4 = 3'd4; i1 = 3'd1; i5 = 3'd5;
    end
    case (kind)
      KIND_TRI, KIND_QUAD: begin
        case (pc)
          5'd0: u = (kind == KIND_TRI) ? mk(OP_VSET, VR_B, 3'd1, 3'd0)
                                       : mk(OP_VSET, VR_B, 3'd2, 3'd0);
          5'd1: u = (kind == KIND_TRI) ? mk(OP_VSET, VR_C, 3'd2, 3'd0)
                                       : mk(OP_VSET, VR_C, 3'd3, 3'd1);
          5'd2: u = mk(OP_CROSS, VR_A, 3'd0, 3'd0);
          5'd3: u = mk(OP_AREA, VR_A, 3'd0, 3'd0);
          default: u = mk(OP_END, VR_A, 3'd0, 3'd0);
        endcase
      end
      KIND_TET: begin
        case (pc)
          5'd0: u = mk(OP_VSET, VR_A, 3'd1, 3'd0);
          5'd1: u = mk(OP_VSET, VR_B, 3'd2, 3'd0);
          5'd2: u = mk(OP_VSET, VR_C, 3'd3, 3'd0);
          5'd3: u = mk(OP_TRIPLE, VR_A, 3'd0, 3'd0);
          5'd4: u = mk(OP_VOL128, VR_A, 3'd0, 3'd0);
          default: u = mk(OP_END, VR_A, 3'd0, 3'd0);
        endcase
      end
      KIND_PYR: begin
        case (pc)
          5'd0: u = mk(OP_VSET, VR_A, 3'd4, 3'd0);
          5'd1: u = mk(OP_VSET, VR_B, 3'd2, 3'd0);
          5'd2: u = mk(OP_VSET, VR_C, 3'd3, 3'd1);
          5'd3: u = mk(OP_TRIPLE, VR_A, 3'd0, 3'd0);
          5'd4: u = mk(OP_VOL128, VR_A, 3'd0, 3'd0);
          default: u = mk(OP_END, VR_A, 3'd0, 3'd0);
        endcase
      end
      default: begin
        case (pc)
          // first term: (r2c1 + r3c1) . (r1c2 x r1c3)
          5'd0:  u = mk(OP_VSET, VR_A, i7, i0);
          5'd1:  u = mk(OP_VADD, VR_A, i6, i1);
          5'd2:  u = mk(OP_VSET, VR_B, i6, i3);
          5'd3:  u = mk(OP_VSET, VR_C, i2, i0);
          5'd4:  u = mk(OP_TRIPLE, VR_A, 3'd0, 3'd0);
          // second term: r2c1 . ((r1c2 + r3c2) x r2c3)
          5'd5:  u = mk(OP_VSET, VR_A, i7, i0);
          5'd6:  u = mk(OP_VSET, VR_B, i6, i3);
          5'd7:  u = mk(OP_VADD, VR_B, i5, i0);
          5'd8:  u = mk(OP_VSET, VR_C, i6, i4);
          5'd9:  u = mk(OP_TRIPLE, VR_A, 3'd0, 3'd0);
          // third term: r3c1 . (r3c2 x (r1c3 + r2c3))
          5'd10: u = mk(OP_VSET, VR_A, i6, i1);
          5'd11: u = mk(OP_VSET, VR_B, i5, i0);
          5'd12: u = mk(OP_VSET, VR_C, i2, i0);
          5'd13: u = mk(OP_VADD, VR_C, i6, i4);
          5'd14: u = mk(OP_TRIPLE, VR_A, 3'd0, 3'd0);
          5'd15: u = mk(OP_VOL64, VR_A, 3'd0, 3'd0);
          default: u = mk(OP_END, VR_A, 3'd0, 3'd0);
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/mshm_div.sv
// Rounded division of a signed 64-bit value by a small divisor (3, 4, 5, 6
// or 8), sixteen quotient bits per cycle by reciprocal multiplication.
// Depends on mshm_pkg.
module mshm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mshm_pkg::div_req_t  req,
  output mshm_pkg::div_rsp_t  rsp
);

  logic        busy_r;
  logic        done_r;
  logic [2:0]  it_r;
  logic        neg_r;
  logic [63:0] q_r;
  logic [2:0]  rem_r;
  logic [3:0]  den_r;
  logic [21:0] recip_r;

  logic [63:0] mag;
  logic [21:0] recip;
  logic [18:0] part;
  logic [40:0] part_prod;
  logic [15:0] qdig;
  logic [18:0] rem_full;

  // magnitude plus half the divisor gives round half away from zero
  always_comb begin
    mag = (req.num[63] ? (64'd0 - req.num) : req.num) + {61'd0, req.den[3:1]};
    // reciprocal scaled by 2^22, exact for partial dividends below 2^19
    case (req.den)
      4'd3:    recip = 22'd1398102;
      4'd4:    recip = 22'd1048576;
      4'd5:    recip = 22'd838861;
      4'd6:    recip = 22'd699051;
      default: recip = 22'd524288;
    endcase
    // one radix-65536 digit: remainder in front of the next 16 dividend bits
    part      = {rem_r, q_r[63:48]};
    part_prod = {22'd0, part} * {19'd0, recip_r};
    qdig      = part_prod[37:22];
    rem_full  = part - ({3'd0, qdig} * {15'd0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= busy_r && (it_r == 3'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        it_r   <= 3'd4;
      end else if (busy_r) begin
        it_r <= it_r - 3'd1;
        if (it_r == 3'd1) busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r   <= req.num[63];
      q_r     <= mag;
      rem_r   <= '0;
      den_r   <= req.den;
      recip_r <= recip;
    end else if (busy_r) begin
      rem_r <= rem_full[2:0];
      q_r   <= {q_r[47:0], qdig};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? (64'sd0 - $signed(q_r)) : $signed(q_r);

endmodule

### hw/rtl/mesh_element_measure.sv
// Mesh element measure: stores vertices, then computes measure, normal,
// centroid and status. Depends on mshm_pkg and mshm_div.
// Vertices: one item per cycle while idle; in_stall holds input while busy.
// Final vertex: busy while summing each stored vertex, running each vector op,
// the products for cross, triple and norm ops, 45 square-root steps for surfaces,
// each division (three centroid axes plus one for solids) and the output load,
// and longer while a result waits. Wrong counts go straight to the output.
// Reset (synchronous) clears the count, sequencer and output valid; the vertex
// memory is not cleared.
module mesh_element_measure (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_shape_kind,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_measure,
  output logic signed [36:0] out_normal_x,
  output logic signed [36:0] out_normal_y,
  output logic signed [36:0] out_normal_z,
  output logic signed [23:0] out_centroid_x,
  output logic signed [23:0] out_centroid_y,
  output logic signed [23:0] out_centroid_z,
  output logic               out_status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_SUMW  = 4'd2;
  localparam logic [3:0] S_OP    = 4'd3;
  localparam logic [3:0] S_VA    = 4'd4;
  localparam logic [3:0] S_VB    = 4'd5;
  localparam logic [3:0] S_VC    = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_DSET  = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                     state_r;
  logic [mshm_pkg::CNT_W-1:0]     count_r;
  logic [mshm_pkg::CNT_W-1:0]     cnt_r;
  logic [2:0]                     kind_r;
  logic                           err_r;
  logic [mshm_pkg::PC_W-1:0]      pc_r;
  logic [mshm_pkg::CNT_W-1:0]     sc_r;
  logic [3:0]                     k_r;
  logic [5:0]                     sq_it_r;
  logic [1:0]                     d_idx_r;
  logic                           out_valid_r;

  // vertex memory, synchronous read
  logic [47:0]                    vmem [mshm_pkg::MAX_VERTICES];
  logic [47:0]                    rd_r;
  logic [mshm_pkg::ADDR_W-1:0]    raddr;

  logic [47:0]                    vi_r;
  logic signed [18:0]             sx_r, sy_r, sz_r;
  mshm_pkg::vec_t                 va_r, vb_r, vc_r;
  mshm_pkg::nvec_t                n_r;
  logic signed [58:0]             p_r;
  logic signed [63:0]             acc_r;
  logic [75:0]                    s_r;
  logic [89:0]                    v_r;
  logic [45:0]                    rem_r;
  logic [44:0]                    root_r;
  logic signed [63:0]             meas_r;
  logic signed [63:0]             meas_num_r;
  logic signed [23:0]             cx_r, cy_r, cz_r;

  logic signed [63:0]             o_meas_r;
  logic signed [36:0]             o_nx_r, o_ny_r, o_nz_r;
  logic signed [23:0]             o_cx_r, o_cy_r, o_cz_r;
  logic                           o_status_r;

  mshm_pkg::uop_t                 uop;
  mshm_pkg::div_req_t             dreq;
  mshm_pkg::div_rsp_t             drsp;

  logic                           in_acc;
  logic [mshm_pkg::CNT_W-1:0]     cnt_nxt;
  logic                           surface;
  logic                           out_load;
  logic                           mul_last;

  logic signed [37:0]             ma;
  logic signed [20:0]             mb;
  logic signed [58:0]             prod;
  logic signed [36:0]             nsel;
  logic [36:0]                    nmag;
  logic [6:0]                     area_sh;

  mshm_pkg::vec_t                 diff, vsrc, vnew;

  logic [46:0]                    sq_sh, sq_trial, sq_nx;
  logic                           sq_ge;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cnt_nxt   = (count_r < 4'(mshm_pkg::MAX_VERTICES)) ? (count_r + 4'd1)
                                                             : 4'(mshm_pkg::MAX_VERTICES + 1);
  assign uop       = mshm_pkg::prog_uop(kind_r, pc_r);
  assign surface   = (kind_r == mshm_pkg::KIND_TRI) || (kind_r == mshm_pkg::KIND_QUAD);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign mul_last  = (uop.op == mshm_pkg::OP_CROSS) ? (k_r == 4'd5) : (k_r == 4'd8);

  // memory read address by sequencer phase
  always_comb begin
    raddr = sc_r[mshm_pkg::ADDR_W-1:0];
    if (state_r == S_VA) raddr = uop.vi;
    else if (state_r == S_VB) raddr = uop.vj;
  end

  always_ff @(posedge clk) begin
    if (in_acc && (count_r < 4'(mshm_pkg::MAX_VERTICES)))
      vmem[count_r[mshm_pkg::ADDR_W-1:0]] <= {in_coord_z, in_coord_y, in_coord_x};
    rd_r <= vmem[raddr];
  end

  // edge vector: stored vertex minus freshly read vertex
  always_comb begin
    diff.x = 18'($signed(vi_r[15:0]))  - 18'($signed(rd_r[15:0]));
    diff.y = 18'($signed(vi_r[31:16])) - 18'($signed(rd_r[31:16]));
    diff.z = 18'($signed(vi_r[47:32])) - 18'($signed(rd_r[47:32]));
    case (uop.dst)
      mshm_pkg::VR_A: vsrc = va_r;
      mshm_pkg::VR_B: vsrc = vb_r;
      default:        vsrc = vc_r;
    endcase
    if (uop.op == mshm_pkg::OP_VADD) begin
      vnew.x = vsrc.x + diff.x;
      vnew.y = vsrc.y + diff.y;
      vnew.z = vsrc.z + diff.z;
    end else begin
      vnew = diff;
    end
  end

  // multiplier operand select
  always_comb begin
    ma      = '0;
    mb      = '0;
    area_sh = 7'd0;
    case (k_r)
      4'd0, 4'd1, 4'd2: nsel = n_r.x;
      4'd3, 4'd4, 4'd5: nsel = n_r.y;
      default:          nsel = n_r.z;
    endcase
    nmag = nsel[36] ? (37'd0 - nsel) : nsel;
    if (uop.op == mshm_pkg::OP_AREA) begin
      // |n|^2 from split halves: hi^2 << 38, 2 hi lo << 19, lo^2
      case (k_r) inside
        4'd0, 4'd3, 4'd6: begin
          ma = {20'd0, nmag[36:19]}; mb = {3'd0, nmag[36:19]}; area_sh = 7'd38;
        end
        4'd1, 4'd4, 4'd7: begin
          ma = {20'd0, nmag[36:19]}; mb = {2'd0, nmag[18:0]}; area_sh = 7'd20;
        end
        default: begin
          ma = {19'd0, nmag[18:0]}; mb = {2'd0, nmag[18:0]}; area_sh = 7'd0;
        end
      endcase
    end else begin
      case (k_r)
        4'd0: begin ma = 38'(vb_r.y); mb = 21'(vc_r.z); end
        4'd1: begin ma = 38'(vb_r.z); mb = 21'(vc_r.y); end
        4'd2: begin ma = 38'(vb_r.z); mb = 21'(vc_r.x); end
        4'd3: begin ma = 38'(vb_r.x); mb = 21'(vc_r.z); end
        4'd4: begin ma = 38'(vb_r.x); mb = 21'(vc_r.y); end
        4'd5: begin ma = 38'(vb_r.y); mb = 21'(vc_r.x); end
        4'd6: begin ma = 38'(n_r.x);  mb = 21'(va_r.x); end
        4'd7: begin ma = 38'(n_r.y);  mb = 21'(va_r.y); end
        default: begin ma = 38'(n_r.z); mb = 21'(va_r.z); end
      endcase
    end
    prod = ma * mb;
  end

  // one square-root digit per cycle
  always_comb begin
    sq_sh    = {rem_r[44:0], v_r[89:88]};
    sq_trial = {root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_nx    = sq_ge ? (sq_sh - sq_trial) : sq_sh;
  end

  // divider request
  always_comb begin
    dreq.start = (state_r == S_DSET);
    dreq.den   = cnt_r;
    case (d_idx_r)
      2'd0: dreq.num = {{37{sx_r[18]}}, sx_r, 8'd0};
      2'd1: dreq.num = {{37{sy_r[18]}}, sy_r, 8'd0};
      2'd2: dreq.num = {{37{sz_r[18]}}, sz_r, 8'd0};
      default: begin
        dreq.num = meas_num_r;
        dreq.den = mshm_pkg::VOL_DEN;
      end
    endcase
  end

  mshm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_last_vertex) begin
              count_r <= '0;
              state_r <= (cnt_nxt != mshm_pkg::need_count(in_shape_kind)) ? S_OUT : S_SUM;
            end else begin
              count_r <= cnt_nxt;
            end
          end
        end
        S_SUM:  state_r <= S_SUMW;
        S_SUMW: state_r <= ((sc_r + 4'd1) == cnt_r) ? S_OP : S_SUM;
        S_OP: begin
          case (uop.op) inside
            mshm_pkg::OP_VSET, mshm_pkg::OP_VADD: state_r <= S_VA;
            mshm_pkg::OP_CROSS, mshm_pkg::OP_TRIPLE, mshm_pkg::OP_AREA: state_r <= S_MUL;
            mshm_pkg::OP_END: state_r <= S_DSET;
            default: state_r <= S_OP;
          endcase
        end
        S_VA:  state_r <= S_VB;
        S_VB:  state_r <= S_VC;
        S_VC:  state_r <= S_OP;
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (!mul_last) state_r <= S_MUL;
          else if (uop.op == mshm_pkg::OP_AREA) state_r <= S_SQRT;
          else state_r <= S_OP;
        end
        S_SQRT:  if (sq_it_r == 6'd1) state_r <= S_OP;
        S_DSET:  state_r <= S_DWAIT;
        S_DWAIT: begin
          if (drsp.done) begin
            if ((d_idx_r == 2'd3) || ((d_idx_r == 2'd2) && surface)) state_r <= S_OUT;
            else state_r <= S_DSET;
          end
        end
        S_OUT:   if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_last_vertex) begin
          cnt_r   <= cnt_nxt;
          kind_r  <= in_shape_kind;
          err_r   <= cnt_nxt != mshm_pkg::need_count(in_shape_kind);
          sx_r    <= '0;
          sy_r    <= '0;
          sz_r    <= '0;
          acc_r   <= '0;
          sc_r    <= '0;
          pc_r    <= '0;
          d_idx_r <= '0;
        end
      end
      S_SUMW: begin
        sx_r <= sx_r + 19'($signed(rd_r[15:0]));
        sy_r <= sy_r + 19'($signed(rd_r[31:16]));
        sz_r <= sz_r + 19'($signed(rd_r[47:32]));
        sc_r <= sc_r + 4'd1;
      end
      S_OP: begin
        k_r <= '0;
        if (uop.op == mshm_pkg::OP_AREA) s_r <= '0;
        if (uop.op == mshm_pkg::OP_VOL128) begin
          meas_num_r <= acc_r <<< 7;
          pc_r       <= pc_r + 5'd1;
        end else if (uop.op == mshm_pkg::OP_VOL64) begin
          meas_num_r <= acc_r <<< 6;
          pc_r       <= pc_r + 5'd1;
        end
      end
      S_VB: vi_r <= rd_r;
      S_VC: begin
        case (uop.dst)
          mshm_pkg::VR_A: va_r <= vnew;
          mshm_pkg::VR_B: vb_r <= vnew;
          default:        vc_r <= vnew;
        endcase
        pc_r <= pc_r + 5'd1;
      end
      S_MUL: p_r <= prod;
      S_ACC: begin
        if (uop.op == mshm_pkg::OP_AREA) begin
          s_r <= s_r + (76'(p_r[57:0]) << area_sh);
        end else begin
          case (k_r)
            4'd0: n_r.x <= p_r[36:0];
            4'd1: n_r.x <= n_r.x - p_r[36:0];
            4'd2: n_r.y <= p_r[36:0];
            4'd3: n_r.y <= n_r.y - p_r[36:0];
            4'd4: n_r.z <= p_r[36:0];
            4'd5: n_r.z <= n_r.z - p_r[36:0];
            default: acc_r <= acc_r + {{5{p_r[58]}}, p_r};
          endcase
        end
        k_r <= k_r + 4'd1;
        if (mul_last) begin
          if (uop.op == mshm_pkg::OP_AREA) begin
            v_r     <= {s_r + (76'(p_r[57:0]) << area_sh), 14'd0};
            rem_r   <= '0;
            root_r  <= '0;
            sq_it_r <= 6'd45;
          end else begin
            pc_r <= pc_r + 5'd1;
          end
        end
      end
      S_SQRT: begin
        rem_r   <= sq_nx[45:0];
        root_r  <= {root_r[43:0], sq_ge};
        v_r     <= {v_r[87:0], 2'b00};
        sq_it_r <= sq_it_r - 6'd1;
        if (sq_it_r == 6'd1) begin
          meas_r <= {19'd0, root_r[43:0], sq_ge};
          pc_r   <= pc_r + 5'd1;
        end
      end
      S_DWAIT: begin
        if (drsp.done) begin
          case (d_idx_r)
            2'd0:    cx_r   <= drsp.quo[23:0];
            2'd1:    cy_r   <= drsp.quo[23:0];
            2'd2:    cz_r   <= drsp.quo[23:0];
            default: meas_r <= drsp.quo;
          endcase
          d_idx_r <= d_idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r <= err_r;
      o_meas_r   <= err_r ? 64'sd0 : meas_r;
      o_nx_r     <= (err_r || !surface) ? 37'sd0 : n_r.x;
      o_ny_r     <= (err_r || !surface) ? 37'sd0 : n_r.y;
      o_nz_r     <= (err_r || !surface) ? 37'sd0 : n_r.z;
      o_cx_r     <= err_r ? 24'sd0 : cx_r;
      o_cy_r     <= err_r ? 24'sd0 : cy_r;
      o_cz_r     <= err_r ? 24'sd0 : cz_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_measure    = o_meas_r;
  assign out_normal_x   = o_nx_r;
  assign out_normal_y   = o_ny_r;
  assign out_normal_z   = o_nz_r;
  assign out_centroid_x = o_cx_r;
  assign out_centroid_y = o_cy_r;
  assign out_centroid_z = o_cz_r;
  assign out_status     = o_status_r;

endmodule

### hw/rtl/mshm_chk.sv
// Port-level checks for mesh_element_measure, attached by bind.
// Depends only on the top level's ports.
module mshm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_shape_kind,
  input logic signed [15:0] in_coord_x,
  input logic signed [15:0] in_coord_y,
  input logic signed [15:0] in_coord_z,
  input logic               in_last_vertex,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] out_measure,
  input logic signed [36:0] out_normal_x,
  input logic signed [36:0] out_normal_y,
  input logic signed [36:0] out_normal_z,
  input logic signed [23:0] out_centroid_x,
  input logic signed [23:0] out_centroid_y,
  input logic signed [23:0] out_centroid_z,
  input logic               out_status
);

  // a held result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  // a held result keeps its measure
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_measure)) else $error("stalled result changed");

  // closing an element makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_vertex |=> in_stall)
    else $error("item accepted while element in flight");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_measure == 64'sd0 && out_normal_x == 37'sd0 &&
    out_normal_y == 37'sd0 && out_normal_z == 37'sd0 && out_centroid_x == 24'sd0 &&
    out_centroid_y == 24'sd0 && out_centroid_z == 24'sd0)
    else $error("error result with nonzero fields");

endmodule

bind mesh_element_measure mshm_chk u_mshm_chk (.*);

### dv/tb.sv
// Testbench for mesh_element_measure: drives vertex items, predicts each
// element's measure, normal, centroid and status, and checks every result.
// Depends on mshm_pkg and the mesh_element_measure RTL.
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [63:0] measure;
    logic signed [36:0] nx, ny, nz;
    logic signed [23:0] cx, cy, cz;
    logic               status;
  } elem_result_t;

  typedef struct {
    longint x, y, z;
  } pt_t;

  // Scoreboard: own vertex store and count, queue of expected element results
  class element_scoreboard;
    pt_t          pts[mshm_pkg::MAX_VERTICES];
    int           count;
    elem_result_t pending[$];
    int           errors;

    function pt_t psub(pt_t a, pt_t b);
      pt_t r;
      r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
      return r;
    endfunction

    function pt_t padd(pt_t a, pt_t b);
      pt_t r;
      r.x = a.x + b.x; r.y = a.y + b.y; r.z = a.z + b.z;
      return r;
    endfunction

    function pt_t pcross(pt_t a, pt_t b);
      pt_t r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
    endfunction

    function longint pdot(pt_t a, pt_t b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function longint rdiv(longint num, longint d);
      if (num >= 0) return (num + d / 2) / d;
      return -((-num + d / 2) / d);
    endfunction

    // floor(sqrt(16384 * |n|^2)) with wide math; squares exceed 64 bits
    function longint area(pt_t n);
      logic [143:0] s, c;
      logic [63:0]  r;
      s = 144'(n.x) * 144'(n.x) + 144'(n.y) * 144'(n.y) + 144'(n.z) * 144'(n.z);
      s = s << 14;
      r = 0;
      for (int b = 42; b >= 0; b--) begin
        c = 144'(r | (64'd1 << b));
        if (c * c <= s) r = r | (64'd1 << b);
      end
      return longint'(r);
    endfunction

    // sum of three triple products over solid edge vectors
    function longint vol12(int i6, int i3, int i2, int i0, int i7, int i4, int i1,
                           int i5);
      pt_t a12, a13, a21, a23, a31, a32;
      a12 = psub(pts[i6], pts[i3]); a13 = psub(pts[i2], pts[i0]);
      a21 = psub(pts[i7], pts[i0]); a23 = psub(pts[i6], pts[i4]);
      a31 = psub(pts[i6], pts[i1]); a32 = psub(pts[i5], pts[i0]);
      return pdot(padd(a21, a31), pcross(a12, a13))
           + pdot(a21, pcross(padd(a12, a32), a23))
           + pdot(a31, pcross(a32, padd(a13, a23)));
    endfunction

    function void note_vertex(logic [2:0] kind, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z,
                              logic last);
      elem_result_t e;
      pt_t n, q;
      longint sx, sy, sz, m;
      int cnt;
      if (count < mshm_pkg::MAX_VERTICES) begin
        pts[count].x = x; pts[count].y = y; pts[count].z = z;
        count++;
      end else count = mshm_pkg::MAX_VERTICES + 1;
      if (!last) return;
      cnt = count;
      count = 0;
      n = '{0, 0, 0};
      m = 0; sx = 0; sy = 0; sz = 0;
      e.status = (cnt != mshm_pkg::need_count(kind));
      e.cx = 0; e.cy = 0; e.cz = 0;
      if (!e.status) begin
        for (int i = 0; i < cnt; i++) begin
          sx += pts[i].x; sy += pts[i].y; sz += pts[i].z;
        end
        e.cx = 24'(rdiv(sx * 256, cnt));
        e.cy = 24'(rdiv(sy * 256, cnt));
        e.cz = 24'(rdiv(sz * 256, cnt));
        case (kind)
          mshm_pkg::KIND_TRI: begin
            n = pcross(psub(pts[1], pts[0]), psub(pts[2], pts[0]));
            m = area(n);
          end
          mshm_pkg::KIND_QUAD: begin
            n = pcross(psub(pts[2], pts[0]), psub(pts[3], pts[1]));
            m = area(n);
          end
          mshm_pkg::KIND_TET: m = rdiv(pdot(psub(pts[1], pts[0]),
                        pcross(psub(pts[2], pts[0]), psub(pts[3], pts[0]))) * 128, 3);
          mshm_pkg::KIND_PYR: begin
            q = pcross(psub(pts[2], pts[0]), psub(pts[3], pts[1]));
            m = rdiv(pdot(psub(pts[4], pts[0]), q) * 128, 3);
          end
          mshm_pkg::KIND_PRISM: m = rdiv(vol12(5, 2, 2, 0, 5, 3, 1, 4) * 64, 3);
          default:    m = rdiv(vol12(6, 3, 2, 0, 7, 4, 1, 5) * 64, 3);
        endcase
      end
      e.measure = m;
      e.nx = 37'(n.x); e.ny = 37'(n.y); e.nz = 37'(n.z);
      pending.push_back(e);
    endfunction

    function void check_result(elem_result_t a);
      elem_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: measure %0d", a.measure);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.measure !== e.measure) begin
        $error("measure exp %0d got %0d", e.measure, a.measure); errors++;
      end
      if (a.nx !== e.nx) begin $error("normal_x exp %0d got %0d", e.nx, a.nx); errors++; end
      if (a.ny !== e.ny) begin $error("normal_y exp %0d got %0d", e.ny, a.ny); errors++; end
      if (a.nz !== e.nz) begin $error("normal_z exp %0d got %0d", e.nz, a.nz); errors++; end
      if (a.cx !== e.cx) begin
        $error("centroid_x exp %0d got %0d", e.cx, a.cx); errors++;
      end
      if (a.cy !== e.cy) begin
        $error("centroid_y exp %0d got %0d", e.cy, a.cy); errors++;
      end
      if (a.cz !== e.cz) begin
        $error("centroid_z exp %0d got %0d", e.cz, a.cz); errors++;
      end
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [2:0]         in_shape_kind = 0;
  logic signed [15:0] in_coord_x = 0, in_coord_y = 0, in_coord_z = 0;
  logic               in_last_vertex = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [63:0] out_measure;
  logic signed [36:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [23:0] out_centroid_x, out_centroid_y, out_centroid_z;
  logic               out_status;

  element_scoreboard board = new();
  int  send_idle_pct = 35, recv_idle_pct = 85;
  longint cycles = 0;

  mesh_element_measure uut (.*);

  always #2 clk = ~clk;

  // receiver: random stall, check on accept
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      board.check_result('{out_measure, out_normal_x, out_normal_y, out_normal_z,
                           out_centroid_x, out_centroid_y, out_centroid_z, out_status});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // timeout guard
  always @(posedge clk)
    if (cycles > 3000000) begin
      $display("mesh_element_measure verification failed");
      $finish;
    end

  // one vertex item, with random idle cycles before it
  task automatic send_vertex(logic [2:0] kind, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_shape_kind <= kind;
    in_coord_x <= x; in_coord_y <= y; in_coord_z <= z;
    in_last_vertex <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_vertex(kind, x, y, z, last);
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
      default: return 16'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  // one element of given kind and vertex count
  task automatic send_element(logic [2:0] kind, int nv, int mode);
    for (int i = 0; i < nv; i++)
      send_vertex(kind, rand_coord(mode), rand_coord(mode), rand_coord(mode), i == nv - 1);
  endtask

  function automatic int kind_need(logic [2:0] k);
    return mshm_pkg::need_count(k);
  endfunction

  initial begin
    int sent;
    logic [2:0] k;
    int nv, mode;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: each kind at extremes, and a few bad counts
    send_vertex(mshm_pkg::KIND_TRI, 0, 0, 0, 0);
    send_vertex(mshm_pkg::KIND_TRI, 16'sh7fff, -16'sh8000, 16'sh7fff, 0);
    send_vertex(mshm_pkg::KIND_TRI, -16'sh8000, 16'sh7fff, -16'sh8000, 1);
    for (int kk = mshm_pkg::KIND_QUAD; kk <= mshm_pkg::KIND_HEX; kk++)
      send_element(3'(kk), kind_need(3'(kk)), 1);
    send_element(3'd6, 3, 2);
    send_element(3'd7, 1, 2);
    send_element(mshm_pkg::KIND_HEX, 10, 0);   // overflow past the store
    send_element(mshm_pkg::KIND_TRI, 2, 2);    // short count

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 35 : 0;
      while (sent < (phase + 1) * 383) begin
        k = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
        nv = kind_need(k);
        if (nv == 0 || $urandom_range(9) == 0) nv = $urandom_range(10, 1);
        mode = $urandom_range(9) < 7 ? 0 : $urandom_range(2, 1);
        send_element(k, nv, mode);
        sent += nv;
      end
    end
    in_valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0)
      $display("mesh_element_measure verification clean");
    else
      $display("mesh_element_measure verification failed");
    $finish;
  end
endmodule

### files.f
hw/rtl/mshm_pkg.sv
hw/rtl/mshm_div.sv
hw/rtl/mesh_element_measure.sv
hw/rtl/mshm_chk.sv
dv/tb.sv
